FILE: sv/pib_pkg.sv
// shared types and constants for the point-in-region test block
// no dependencies; imported by the front, back and top level
`timescale 1ns / 1ps

package pib_pkg;

  localparam int COORD_W    = 12;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_ENABLE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_X_A      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_X_B      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_Y_A      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_Y_B      = 3'd5;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_POLY,
    OP_RESULT
  } pib_op_t;

  typedef struct packed {
    pib_op_t             op;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    cnt;
    logic                res;
  } pib_cmd_t;

endpackage

FILE: sv/polygon_or_box_bounds_test.sv
// top level of the point-in-region test block
// depends on pib_pkg, pib_front, pib_fifo and pib_back
`timescale 1ns / 1ps

// Input items enter through a queue-like port: an item transfers when push is
// high and full is low. req_type 1 stores a vertex (pos_x, pos_y) at
// vertex_slot; req_type 0 tests the point (pos_x, pos_y) and yields one result.
// Results leave through a second queue: inside_res is valid while empty is low
// and transfers when pop is high. Configuration is written through cfg_we,
// cfg_addr and cfg_wdata; the user must write it only while the block holds
// no unfinished item, which the block itself does not enforce. The front end
// classifies an item in the cycle it arrives and settles box tests there; a
// two-entry command queue separates it from the back end. The back end takes
// one command a cycle from that queue for vertex writes and box results (box
// results only while the result queue has room); a polygon test walks the
// vertex memory one edge a cycle through a single read port, so the back end
// takes no new command until its result is emitted. When pop stays low the
// result queue fills, the back end stalls, then the command queue fills and
// full rises. Reset empties both queues and restores the register defaults;
// the vertex memory keeps no reset value.
module polygon_or_box_bounds_test #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pib_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [pib_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            push,
  output logic                            full,
  input  logic                            req_type,
  input  logic [pib_pkg::COORD_W-1:0]     pos_x,
  input  logic [pib_pkg::COORD_W-1:0]     pos_y,
  input  logic [pib_pkg::SLOT_W-1:0]      vertex_slot,
  output logic                            empty,
  input  logic                            pop,
  output logic                            inside_res
);

  import pib_pkg::*;

  logic     cmd_push;
  logic     cmd_pop;
  logic     cmd_empty;
  pib_cmd_t cmd_in;
  pib_cmd_t cmd_out;
  logic     res_push;
  logic     res_full;
  logic     res_bit;

  pib_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .vertex_slot (vertex_slot),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  pib_fifo #(
    .WIDTH ($bits(pib_cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  pib_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_bit   (res_bit)
  );

  pib_fifo #(
    .WIDTH (1),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_bit),
    .full  (res_full),
    .pop   (pop),
    .rdata (inside_res),
    .empty (empty)
  );

endmodule

FILE: sv/pib_fifo.sv
// small synchronous queue with full/empty flags
// no dependencies; used for the command queue and the result queue
`timescale 1ns / 1ps

module pib_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wptr] <= wdata;
    end
  end

endmodule

FILE: sv/pib_front.sv
// front end: configuration registers, item classification and box test
// depends on pib_pkg; feeds the command queue read by pib_back
`timescale 1ns / 1ps

module pib_front #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pib_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [pib_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            push,
  input  logic                            full,
  input  logic                            req_type,
  input  logic [pib_pkg::COORD_W-1:0]     pos_x,
  input  logic [pib_pkg::COORD_W-1:0]     pos_y,
  input  logic [pib_pkg::SLOT_W-1:0]      vertex_slot,
  output logic                            cmd_push,
  output pib_pkg::pib_cmd_t               cmd
);

  import pib_pkg::*;

  logic [CNT_W-1:0]   vertex_count;
  logic               box_enable;
  logic [COORD_W-1:0] box_x_a;
  logic [COORD_W-1:0] box_x_b;
  logic [COORD_W-1:0] box_y_a;
  logic [COORD_W-1:0] box_y_b;

  logic               slot_ok;
  logic [CNT_W-1:0]   n_used;
  logic               x_in;
  logic               y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      box_enable   <= 1'b0;
      box_x_a      <= '0;
      box_x_b      <= '1;
      box_y_a      <= '0;
      box_y_b      <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VERTEX_COUNT: vertex_count <= cfg_wdata[CNT_W-1:0];
        REG_BOX_ENABLE:   box_enable   <= cfg_wdata[0];
        REG_BOX_X_A:      box_x_a      <= cfg_wdata[COORD_W-1:0];
        REG_BOX_X_B:      box_x_b      <= cfg_wdata[COORD_W-1:0];
        REG_BOX_Y_A:      box_y_a      <= cfg_wdata[COORD_W-1:0];
        REG_BOX_Y_B:      box_y_b      <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // writes beyond the table are dropped here
  assign slot_ok = (32'(vertex_slot) < MAX_VERTICES);
  assign n_used  = (32'(vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vertex_count;

  // box limits may come in either order
  assign x_in = ((pos_x >= box_x_a) && (pos_x <= box_x_b)) ||
                ((pos_x >= box_x_b) && (pos_x <= box_x_a));
  assign y_in = ((pos_y >= box_y_a) && (pos_y <= box_y_b)) ||
                ((pos_y >= box_y_b) && (pos_y <= box_y_a));

  assign cmd_push = push && !full && !(req_type && !slot_ok);

  always_comb begin
    cmd.x    = pos_x;
    cmd.y    = pos_y;
    cmd.slot = vertex_slot;
    cmd.cnt  = n_used;
    cmd.res  = !box_enable || (x_in && y_in);
    if (req_type) begin
      cmd.op = OP_WRITE;
    end else if (n_used != '0) begin
      cmd.op = OP_POLY;
    end else begin
      cmd.op = OP_RESULT;
    end
  end

endmodule

FILE: sv/pib_back.sv
// back end: vertex memory and crossing-number edge walk
// depends on pib_pkg; reads the command queue, writes the result queue
`timescale 1ns / 1ps

module pib_back #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  pib_pkg::pib_cmd_t cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output logic              res_bit
);

  import pib_pkg::*;

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW  = COORD_W + 1;
  localparam int PW  = 2 * DW;
  localparam int CPW = PW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [CNT_W:0]      rd_cnt;
  logic [CNT_W-1:0]    n_reg;
  logic [COORD_W-1:0]  pt_x;
  logic [COORD_W-1:0]  pt_y;
  logic [COORD_W-1:0]  prev_x;
  logic [COORD_W-1:0]  prev_y;
  logic                rd_valid;
  logic                rd_first;
  logic                rd_last;
  logic                s2_valid;
  logic                s2_up;
  logic                s2_down;
  logic                s2_strict;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic                parity;

  logic [2*COORD_W-1:0] mem [MAX_VERTICES];
  logic [2*COORD_W-1:0] mem_q;

  logic                rd_issue;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [COORD_W-1:0]  cur_x;
  logic [COORD_W-1:0]  cur_y;
  logic signed [DW-1:0] dxa;
  logic signed [DW-1:0] dxb;
  logic signed [DW-1:0] dya;
  logic signed [DW-1:0] dyb;
  logic                up;
  logic                down;
  logic signed [CPW-1:0] c_val;
  logic                c_pos;
  logic                c_neg;
  logic                hit;

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty && ((cmd.op != OP_RESULT) || !res_full);
  assign mem_we  = cmd_pop && (cmd.op == OP_WRITE);

  // n+1 reads: vertices 0..n-1, then vertex 0 again for the closing edge
  assign rd_issue = (state == ST_WALK) && (rd_cnt <= {1'b0, n_reg});
  assign rd_addr  = (rd_cnt == {1'b0, n_reg}) ? '0 : AW'(rd_cnt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.slot)] <= {cmd.x, cmd.y};
    end
    mem_q <= mem[rd_addr];
  end

  assign cur_x = mem_q[2*COORD_W-1:COORD_W];
  assign cur_y = mem_q[COORD_W-1:0];

  assign dxa  = $signed({1'b0, prev_x}) - $signed({1'b0, pt_x});
  assign dxb  = $signed({1'b0, cur_x})  - $signed({1'b0, pt_x});
  assign dya  = $signed({1'b0, prev_y}) - $signed({1'b0, pt_y});
  assign dyb  = $signed({1'b0, cur_y})  - $signed({1'b0, pt_y});
  assign up   = (pt_y > prev_y) && (pt_y <= cur_y);
  assign down = (pt_y < prev_y) && (pt_y >= cur_y);

  // sign of the cross product places the intercept left or right of the point
  assign c_val = CPW'(p1) - CPW'(p2);
  assign c_neg = c_val[CPW-1];
  assign c_pos = !c_val[CPW-1] && (c_val != '0);
  assign hit   = (s2_up   && (s2_strict ? c_pos : !c_neg)) ||
                 (s2_down && (s2_strict ? c_neg : !c_pos));

  assign res_push = ((state == ST_IDLE) && cmd_pop && (cmd.op == OP_RESULT)) ||
                    ((state == ST_EMIT) && !res_full);
  assign res_bit  = (state == ST_EMIT) ? parity : cmd.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
      s2_valid <= rd_valid && !rd_first;
      case (state)
        ST_IDLE: begin
          if (cmd_pop && (cmd.op == OP_POLY)) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (s2_valid && s2_strict) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    if (cmd_pop) begin
      pt_x   <= cmd.x;
      pt_y   <= cmd.y;
      n_reg  <= cmd.cnt;
      rd_cnt <= '0;
    end else if (rd_issue) begin
      rd_cnt <= rd_cnt + 1'b1;
    end

    if (rd_issue) begin
      rd_first <= (rd_cnt == '0);
      rd_last  <= (rd_cnt == {1'b0, n_reg});
    end

    if (rd_valid) begin
      prev_x    <= cur_x;
      prev_y    <= cur_y;
      p1        <= dxa * dyb;
      p2        <= dxb * dya;
      s2_up     <= up;
      s2_down   <= down;
      s2_strict <= rd_last;
    end

    if (cmd_pop) begin
      parity <= 1'b0;
    end else if (s2_valid && hit) begin
      parity <= !parity;
    end
  end

  a_s2_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_WALK))
    else $error("edge result outside a polygon walk");

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!rd_valid && !s2_valid))
    else $error("reads still in flight when the result is emitted");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_walk_starts_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) ##1 (state == ST_WALK) |-> (rd_cnt == '0) && !rd_valid)
    else $error("walk did not start from vertex 0");

endmodule
